FILE: sv/sapar_pkg.sv
// ----------------------------------------------------------------------------
// sapar_pkg
// Shared types, sizing constants and the replacement score for the
// set-associative probe table.
// ----------------------------------------------------------------------------
package sapar_pkg;

    localparam int WAYS       = 3;
    localparam int INDEX_BITS = 16;
    localparam int ONE_PLY    = 1;

    localparam int CLUSTERS   = 1 << INDEX_BITS;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W      = 32;
    localparam int KEY_W      = 64;
    localparam int GEN_W      = 6;

    // Age term peaks at 252 * 2 * ONE_PLY; two more bits carry the sign and depth.
    localparam int SCORE_W    = $clog2(252 * 2 * ONE_PLY + 1) + 2;

    localparam logic [7:0] AGE_BIAS = 8'(259);
    localparam logic [7:0] AGE_MASK = 8'hFC;

    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [7:0]       age_bound;
        logic signed [7:0] depth;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  hash_key;
        logic [1:0]        write_way;
        logic signed [7:0] write_depth;
        logic [1:0]        write_bound;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        chosen_way;
        logic signed [7:0] entry_depth;
        logic [1:0]        entry_bound;
    } resolve_t;

    // depth - aged generation distance * 2 * ONE_PLY
    function automatic logic signed [SCORE_W-1:0] repl_score(entry_t e, logic [GEN_W-1:0] gen);
        logic [7:0]                age;
        logic signed [SCORE_W-1:0] d;
        logic signed [SCORE_W-1:0] a;
        age = (AGE_BIAS + {gen, 2'b00} - e.age_bound) & AGE_MASK;
        d   = SCORE_W'(e.depth);
        a   = signed'(SCORE_W'(age));
        return SCORE_W'(d - a * signed'(SCORE_W'(2 * ONE_PLY)));
    endfunction

endpackage

FILE: sv/sapar_if.sv
// ----------------------------------------------------------------------------
// sapar_if
// Handshake channels of the probe table: request, response and the
// search generation write port.
// ----------------------------------------------------------------------------
interface sapar_req_if;
    import sapar_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [KEY_W-1:0]  hash_key;
    logic [1:0]        write_way;
    logic signed [7:0] write_depth;
    logic [1:0]        write_bound;

    modport source (
        output valid, req_type, hash_key, write_way, write_depth, write_bound,
        input  ready
    );
    modport sink (
        input  valid, req_type, hash_key, write_way, write_depth, write_bound,
        output ready
    );
endinterface

interface sapar_rsp_if;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [1:0]        chosen_way;
    logic signed [7:0] entry_depth;
    logic [1:0]        entry_bound;

    modport source (
        output valid, hit, chosen_way, entry_depth, entry_bound,
        input  ready
    );
    modport sink (
        input  valid, hit, chosen_way, entry_depth, entry_bound,
        output ready
    );
endinterface

interface sapar_cfg_if;
    import sapar_pkg::*;

    logic             valid;
    logic             ready;
    logic [GEN_W-1:0] search_generation;

    modport source (
        output valid, search_generation,
        input  ready
    );
    modport sink (
        input  valid, search_generation,
        output ready
    );
endinterface

FILE: sv/set_assoc_probe_age_replace_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_probe_age_replace_unit
// Set-associative probe table with depth/age replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one request per handshake: a probe (req_type 0) looks up the
//          cluster picked by the low key bits, a write (req_type 1) stores
//          tag, depth and bound into write_way of that cluster.
//   rsp  - exactly one response per request, in request order: hit flag,
//          chosen way, and the depth and bound of that way.
//   cfg  - writes search_generation; always ready. Write it only while no
//          request is outstanding.
// Timing: on accept the cluster row is read from the single-port table
//   memory into rd_row_reg; in S_LOOK the row is resolved and written back
//   and the result is loaded into the response register. One request is in flight at a
//   time, so the memory read and write-back never overlap for one row.
// Reset: the table is cleared by a pass over all 2^INDEX_BITS rows, one row
//   a cycle; req.ready stays low until the pass ends. search_generation
//   resets to zero.
// Stall: a response waits in its register while rsp.ready is low; the next
//   request may still be taken and is read, but its write-back and response
//   hold until the register frees.
// ----------------------------------------------------------------------------
module set_assoc_probe_age_replace_unit (
    input  logic        clk,
    input  logic        rst_n,
    sapar_req_if.sink   req,
    sapar_rsp_if.source rsp,
    sapar_cfg_if.sink   cfg
);
    import sapar_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [INDEX_BITS-1:0]   clr_idx_reg;
    logic [INDEX_BITS-1:0]   clr_idx_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [GEN_W-1:0]        gen_reg;

    req_t                    req_reg;
    resolve_t                rsp_reg;

    // Table memory: one row holds all ways of a cluster
    row_t                    mem [CLUSTERS];
    row_t                    rd_row_reg;
    logic                    mem_re;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    row_t                    mem_wdata;

    logic                    accept;
    logic                    commit;
    resolve_t                result;
    row_t                    new_row;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    // Resolve and write back once the response register can take the result
    assign commit    = (state_reg == S_LOOK) && (!out_valid_reg || rsp.ready);

    sapar_resolve u_resolve (
        .row     (rd_row_reg),
        .req     (req_reg),
        .gen     (gen_reg),
        .result  (result),
        .new_row (new_row)
    );

    // Next state, clear sweep and response valid
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Write port: zero rows during the clear sweep, resolved row on commit
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = req_reg.hash_key[INDEX_BITS-1:0];
        mem_wdata = new_row;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (commit)
        begin
            mem_we = 1'b1;
        end
    end

    // Read only on accept so the row holds through a response stall
    assign mem_re = accept;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_row_reg <= mem[req.hash_key[INDEX_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            gen_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                gen_reg <= cfg.search_generation;
            end
        end
    end

    // Payload registers: capture the request, hold the response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.req_type    <= req.req_type;
            req_reg.hash_key    <= req.hash_key;
            req_reg.write_way   <= req.write_way;
            req_reg.write_depth <= req.write_depth;
            req_reg.write_bound <= req.write_bound;
        end
        if (commit)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = rsp_reg.hit;
    assign rsp.chosen_way  = rsp_reg.chosen_way;
    assign rsp.entry_depth = rsp_reg.entry_depth;
    assign rsp.entry_bound = rsp_reg.entry_bound;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOOK)
        else $error("accepted request did not move to lookup");

    a_rsp_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOOK))
        else $error("response raised without a lookup");

    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_valid_reg)
        else $error("response valid during clear sweep");

    a_hit_way_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.hit == 1'b0) || (int'(rsp.chosen_way) < WAYS))
        else $error("hit reported on a way outside the cluster");

endmodule

FILE: sv/sapar_resolve.sv
// ----------------------------------------------------------------------------
// sapar_resolve
// Resolve one request against a cluster row: find the match, empty or
// replacement way, and build the row to write back.
// ----------------------------------------------------------------------------
module sapar_resolve (
    input  sapar_pkg::row_t                  row,
    input  sapar_pkg::req_t                  req,
    input  logic [sapar_pkg::GEN_W-1:0]      gen,
    output sapar_pkg::resolve_t              result,
    output sapar_pkg::row_t                  new_row
);
    import sapar_pkg::*;

    logic [TAG_W-1:0]          key_tag;
    logic                      found;
    logic [WAY_W-1:0]          found_way;
    logic [WAY_W-1:0]          best_way;
    logic signed [SCORE_W-1:0] best_score;
    logic signed [SCORE_W-1:0] score [WAYS];
    logic [WAY_W-1:0]          sel_way;
    entry_t                    sel;
    logic                      way_ok;
    logic                      refresh;

    assign key_tag = req.hash_key[KEY_W-1 -: TAG_W];

    // First way that is empty or carries the tag
    always_comb
    begin
        found     = 1'b0;
        found_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && (row[w].tag == '0 || row[w].tag == key_tag))
            begin
                found     = 1'b1;
                found_way = WAY_W'(w);
            end
        end
    end

    // Lowest score wins, ties keep the lower way
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            score[w] = repl_score(row[w], gen);
        end
        best_way   = '0;
        best_score = score[0];
        for (int w = 1; w < WAYS; w++)
        begin
            if (best_score > score[w])
            begin
                best_way   = WAY_W'(w);
                best_score = score[w];
            end
        end
    end

    assign sel_way = found ? found_way : best_way;

    always_comb
    begin
        sel = row[0];
        for (int w = 0; w < WAYS; w++)
        begin
            if (sel_way == WAY_W'(w))
            begin
                sel = row[w];
            end
        end
    end

    assign refresh = found && (sel.tag != '0) && (sel.age_bound[7:2] != gen);
    assign way_ok  = int'(req.write_way) < WAYS;

    always_comb
    begin
        new_row = row;
        result  = '0;
        if (req.req_type == REQ_WRITE)
        begin
            result.chosen_way = req.write_way;
            if (way_ok)
            begin
                result.entry_depth = req.write_depth;
                result.entry_bound = req.write_bound;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (int'(req.write_way) == w)
                    begin
                        new_row[w].tag       = key_tag;
                        new_row[w].depth     = req.write_depth;
                        new_row[w].age_bound = {gen, req.write_bound};
                    end
                end
            end
        end
        else
        begin
            result.hit         = found && (sel.tag != '0);
            result.chosen_way  = 2'(sel_way);
            result.entry_depth = sel.depth;
            result.entry_bound = sel.age_bound[1:0];
            for (int w = 0; w < WAYS; w++)
            begin
                if (refresh && sel_way == WAY_W'(w))
                begin
                    new_row[w].age_bound = {gen, sel.age_bound[1:0]};
                end
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative probe table. A behavioral
// copy of the table predicts every response as each request is accepted;
// a monitor matches responses against those predictions in order. Directed
// cases cover the boundary situations, then randomized traffic aimed at a
// few crowded clusters runs under three idling profiles and several search
// generations.
// ----------------------------------------------------------------------------
module tb_top;
    import sapar_pkg::*;

    // Run ends here even if the block hangs; covers the full clearing pass
    // plus a few hundred heavily stalled requests many times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int ENTRIES     = CLUSTERS * WAYS;
    localparam int AGE_OFFSET  = 259;
    localparam int GEN_CHUNK   = 45;    // requests between generation changes
    localparam int TAG_POOL_N  = 6;
    localparam int MAX_PRINTED = 40;

    logic clk;
    logic rst_n;

    sapar_req_if req_ch ();
    sapar_rsp_if rsp_ch ();
    sapar_cfg_if cfg_ch ();

    set_assoc_probe_age_replace_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the table and the generation register
    bit [TAG_W-1:0]    tag_mem      [ENTRIES];
    bit [7:0]          agebound_mem [ENTRIES];
    bit signed [7:0]   depth_mem    [ENTRIES];
    logic [GEN_W-1:0]  cur_gen;

    // Responses predicted but not yet seen, oldest first
    resolve_t pending_results[$];

    int error_count;
    int cycle_count;
    int req_idle_pct;
    int rsp_idle_pct;
    int n_probes;
    int n_hits;
    int n_writes;
    int n_gen_writes;
    int gen_step;

    logic [TAG_W-1:0] tag_pool [TAG_POOL_N];
    int               cluster_pool [4];

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Replacement score: depth less twice the aged generation distance.
    function automatic int age_score(input int slot, input logic [7:0] gen8);
        int age;
        age = (AGE_OFFSET + int'(gen8) - int'(agebound_mem[slot])) & int'(AGE_MASK);
        return int'(depth_mem[slot]) - age * 2 * ONE_PLY;
    endfunction

    // Apply one request to the shadow table and return its response.
    function automatic resolve_t resolve_request(input req_t r);
        resolve_t         res;
        int               base;
        int               slot;
        int               best_way;
        int               best_score;
        int               s;
        logic [TAG_W-1:0] key_tag;
        logic [7:0]       gen8;

        res      = '0;
        gen8     = {cur_gen, 2'b00};
        base     = int'(r.hash_key[INDEX_BITS-1:0]) * WAYS;
        key_tag  = r.hash_key[KEY_W-1 -: TAG_W];

        if (r.req_type == REQ_WRITE)
        begin
            n_writes++;
            res.chosen_way = r.write_way;
            // Out-of-range way stores nothing and echoes zero contents
            if (int'(r.write_way) < WAYS)
            begin
                slot               = base + int'(r.write_way);
                tag_mem[slot]      = key_tag;
                depth_mem[slot]    = r.write_depth;
                agebound_mem[slot] = gen8 | {6'b0, r.write_bound};
                res.entry_depth    = r.write_depth;
                res.entry_bound    = r.write_bound;
            end
            return res;
        end

        n_probes++;
        // Stop at the first empty way or tag match; refresh a stale age
        for (int w = 0; w < WAYS; w++)
        begin
            slot = base + w;
            if (tag_mem[slot] == '0 || tag_mem[slot] == key_tag)
            begin
                if (tag_mem[slot] != '0 && (agebound_mem[slot] & AGE_MASK) != gen8)
                    agebound_mem[slot] = gen8 | {6'b0, agebound_mem[slot][1:0]};
                res.hit         = (tag_mem[slot] != '0);
                res.chosen_way  = 2'(w);
                res.entry_depth = depth_mem[slot];
                res.entry_bound = agebound_mem[slot][1:0];
                if (res.hit)
                    n_hits++;
                return res;
            end
        end

        // Cluster full with no match: lowest score wins, ties to lower way
        best_way   = 0;
        best_score = age_score(base, gen8);
        for (int w = 1; w < WAYS; w++)
        begin
            s = age_score(base + w, gen8);
            if (best_score > s)
            begin
                best_way   = w;
                best_score = s;
            end
        end
        res.chosen_way  = 2'(best_way);
        res.entry_depth = depth_mem[base + best_way];
        res.entry_bound = agebound_mem[base + best_way][1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Place a tag and a cluster into a key; fill the bits between at random.
    function automatic logic [KEY_W-1:0] make_key(input logic [TAG_W-1:0] tag,
                                                  input int cluster);
        logic [KEY_W-1:0] k;
        k = {tag, 32'($urandom)};
        k[INDEX_BITS-1:0] = INDEX_BITS'(cluster);
        return k;
    endfunction

    // Send one request. Enter and leave at a falling edge; valid stays high
    // on return so the next request can follow without a bubble.
    task automatic send_request(input logic rtype, input logic [KEY_W-1:0] key,
                                input logic [1:0] way, input logic signed [7:0] depth,
                                input logic [1:0] bound);
        req_t r;
        r.req_type    = rtype;
        r.hash_key    = key;
        r.write_way   = way;
        r.write_depth = depth;
        r.write_bound = bound;
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.req_type;
        req_ch.hash_key    <= r.hash_key;
        req_ch.write_way   <= r.write_way;
        req_ch.write_depth <= r.write_depth;
        req_ch.write_bound <= r.write_bound;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(resolve_request(r));
        @(negedge clk);
    endtask

    // Write the search generation once the block has drained.
    task automatic set_generation(input logic [GEN_W-1:0] g);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.search_generation <= g;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cur_gen = g;
        n_gen_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        // Cap the log; every mismatch still counts
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    localparam logic [TAG_W-1:0] TAG_A = 32'h0000_0001;
    localparam logic [TAG_W-1:0] TAG_B = 32'hFFFF_FFFF;
    localparam logic [TAG_W-1:0] TAG_C = 32'h8000_0000;
    localparam logic [TAG_W-1:0] TAG_D = 32'h5A5A_A5A5;
    localparam int CL_ONE = 16'h0123;
    localparam int CL_TWO = 16'h0456;

    // Freshly cleared table: a zero-tag key and a normal key both land on
    // way 0 as empty, no hit.
    task automatic test_empty_cluster();
        send_request(REQ_PROBE, make_key('0, 0), 2'd0, 8'sd0, 2'd0);
        send_request(REQ_PROBE, make_key(TAG_A, CL_ONE), 2'd3, -8'sd1, 2'd3);
    endtask

    // Fill one cluster at the top generation with depth extremes, try the
    // out-of-range way, then hit and miss it.
    task automatic test_fill_and_match();
        set_generation(6'd63);
        send_request(REQ_WRITE, make_key(TAG_A, CL_ONE), 2'd0, -8'sd128, 2'd0);
        send_request(REQ_WRITE, make_key(TAG_B, CL_ONE), 2'd1, 8'sd127, 2'd3);
        send_request(REQ_WRITE, make_key(TAG_C, CL_ONE), 2'd2, 8'sd0, 2'd1);
        send_request(REQ_WRITE, make_key(TAG_D, CL_ONE), 2'd3, 8'sd127, 2'd2);
        send_request(REQ_PROBE, make_key(TAG_B, CL_ONE), 2'd0, 8'sd0, 2'd0);
        send_request(REQ_PROBE, make_key(TAG_D, CL_ONE), 2'd0, 8'sd0, 2'd0);
    endtask

    // Age the full cluster, refresh one entry, replace again; then a tie on
    // equal scores must go to the lowest way.
    task automatic test_age_replacement();
        set_generation(6'd0);
        send_request(REQ_PROBE, make_key(TAG_D, CL_ONE), 2'd0, 8'sd0, 2'd0);
        send_request(REQ_PROBE, make_key(TAG_C, CL_ONE), 2'd0, 8'sd0, 2'd0);
        set_generation(6'd20);
        send_request(REQ_PROBE, make_key(TAG_D, CL_ONE), 2'd0, 8'sd0, 2'd0);
        for (int w = 0; w < WAYS; w++)
            send_request(REQ_WRITE, make_key(tag_pool[w], CL_TWO), 2'(w), 8'sd5, 2'd2);
        send_request(REQ_PROBE, make_key(TAG_D, CL_TWO), 2'd0, 8'sd0, 2'd0);
    endtask

    // All-ones key in the last cluster, zero-tag keys, and a zero-tag write
    // that turns an occupied way back into an empty one.
    task automatic test_key_extremes();
        send_request(REQ_WRITE, {KEY_W{1'b1}}, 2'd2, -8'sd1, 2'd3);
        send_request(REQ_PROBE, {KEY_W{1'b1}}, 2'd0, 8'sd0, 2'd0);
        send_request(REQ_PROBE, make_key('0, CLUSTERS - 1), 2'd0, 8'sd0, 2'd0);
        send_request(REQ_WRITE, make_key('0, CL_ONE), 2'd0, 8'sd9, 2'd1);
        send_request(REQ_PROBE, make_key(TAG_D, CL_ONE), 2'd0, 8'sd0, 2'd0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly keys drawn from a small tag pool into a few
    // clusters so ways fill, match and get replaced; the rest is noise.
    // The generation moves every few dozen requests to leave stale ages.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int n_items, input int req_pct,
                                       input int rsp_pct);
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic             rtype;
        logic [GEN_W-1:0] g;
        req_idle_pct = req_pct;
        rsp_idle_pct = rsp_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % GEN_CHUNK == 0)
            begin
                g = (gen_step == 0) ? '0 : (gen_step == 1) ? '1 : GEN_W'($urandom);
                gen_step++;
                set_generation(g);
            end
            if ($urandom_range(0, 99) < 12)
                key = {$urandom, $urandom};
            else
            begin
                tag = ($urandom_range(0, 19) == 0) ? '0
                    : tag_pool[$urandom_range(0, TAG_POOL_N - 1)];
                key = make_key(tag, cluster_pool[$urandom_range(0, 3)]);
            end
            rtype = ($urandom_range(0, 99) < 40) ? REQ_WRITE : REQ_PROBE;
            send_request(rtype, key, 2'($urandom), 8'($urandom), 2'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Response monitor: match each accepted response with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        resolve_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b",
                                              rsp_ch.hit, want.hit));
                if (rsp_ch.chosen_way !== want.chosen_way)
                    report_mismatch($sformatf("chosen_way %0d, expected %0d",
                                              rsp_ch.chosen_way, want.chosen_way));
                if (rsp_ch.entry_depth !== want.entry_depth)
                    report_mismatch($sformatf("entry_depth %0d, expected %0d",
                                              rsp_ch.entry_depth, want.entry_depth));
                if (rsp_ch.entry_bound !== want.entry_bound)
                    report_mismatch($sformatf("entry_bound %0d, expected %0d",
                                              rsp_ch.entry_bound, want.entry_bound));
            end
        end
    end

    // Randomly hold back the response side
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value before anything else
        rst_n                    = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.req_type          = REQ_PROBE;
        req_ch.hash_key          = '0;
        req_ch.write_way         = '0;
        req_ch.write_depth       = '0;
        req_ch.write_bound       = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.search_generation = '0;
        cur_gen                  = '0;
        error_count              = 0;
        cycle_count              = 0;
        n_probes                 = 0;
        n_hits                   = 0;
        n_writes                 = 0;
        n_gen_writes             = 0;
        gen_step                 = 0;
        req_idle_pct             = 25;
        rsp_idle_pct             = 61;

        for (int i = 0; i < TAG_POOL_N; i++)
        begin
            tag_pool[i] = $urandom;
            if (tag_pool[i] == '0)
                tag_pool[i] = TAG_B;
        end
        cluster_pool[0] = 0;
        cluster_pool[1] = 1;
        cluster_pool[2] = CLUSTERS - 1;
        cluster_pool[3] = $urandom_range(2, CLUSTERS - 2);

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed cases under the first idling profile
        test_empty_cluster();
        test_fill_and_match();
        test_age_replacement();
        test_key_extremes();

        // Random traffic: receiver-heavy idling, then sender-heavy, then none
        test_random_traffic(135, 25, 61);
        test_random_traffic(135, 61, 25);
        test_random_traffic(135, 0, 0);

        // Drain, then give the block time to show any stray response
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d probes (%0d hits) and %0d writes over %0d generation settings",
                 n_probes, n_hits, n_writes, n_gen_writes);
        $display("Mismatches counted: %0d, cycles run: %0d", error_count, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
